// File: sv/bra_pkg.sv
package bra_pkg;

    localparam int BITS        = 4096;
    localparam int WORD_W      = 32;
    localparam int STORE_WORDS = (BITS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int BIT_AW      = $clog2(WORD_W);

    localparam int IDX_W       = 12;
    localparam int LEN_W       = 13;
    localparam int BYTES_W     = 10;
    localparam int START_W     = 12;

    localparam int USED_W      = BYTES_W + 3;
    localparam int RUN_W       = $clog2(STORE_WORDS * WORD_W + 1);
    localparam int POS_W       = WORD_AW + BIT_AW;
    localparam int CMP_A       = (RUN_W + 1 > LEN_W) ? RUN_W + 1 : LEN_W;
    localparam int CMP_W       = (CMP_A > POS_W + 1) ? CMP_A : POS_W + 1;

    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(512);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_TEST  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_FIND  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_WRITE,
        S_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               clr;
    } store_req_t;

    typedef struct packed {
        logic              hit;
        logic [BIT_AW-1:0] pos;
        logic [RUN_W-1:0]  run_out;
    } eval_res_t;

endpackage

// File: sv/bra_if.sv
interface bra_req_if;
    import bra_pkg::*;

    logic             valid;
    logic             ready;
    func_t            func;
    logic [IDX_W-1:0] bit_index;
    logic             set_value;
    logic [LEN_W-1:0] run_length;

    modport source (output valid, output func, output bit_index, output set_value,
                    output run_length, input ready);
    modport sink   (input valid, input func, input bit_index, input set_value,
                    input run_length, output ready);
endinterface

interface bra_rsp_if;
    import bra_pkg::*;

    logic               valid;
    logic               ready;
    logic               bit_value;
    logic               found;
    logic [START_W-1:0] start_index;

    modport source (output valid, output bit_value, output found, output start_index,
                    input ready);
    modport sink   (input valid, input bit_value, input found, input start_index,
                    output ready);
endinterface

interface bra_cfg_if;
    import bra_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTES_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/bra_store.sv
module bra_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bra_pkg::store_req_t              req,
    output logic [bra_pkg::WORD_W-1:0]       rd_word
);
    import bra_pkg::*;

    logic [WORD_W-1:0]      mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_vld_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // per-word valid bits stand in for clearing the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: sv/bra_word_eval.sv
module bra_word_eval (
    input  logic [bra_pkg::WORD_W-1:0]  word,
    input  logic [bra_pkg::RUN_W-1:0]   carry,
    input  logic [bra_pkg::LEN_W-1:0]   len,
    input  logic [bra_pkg::BIT_AW:0]    nbits,
    output bra_pkg::eval_res_t          res
);
    import bra_pkg::*;

    logic              flag [BIT_AW+1][WORD_W];
    logic [BIT_AW-1:0] lpos [BIT_AW+1][WORD_W];
    logic [CMP_W-1:0]  run_j;
    logic [WORD_W-1:0] ge;
    logic [WORD_W-1:0] low;
    logic [BIT_AW-1:0] pos;

    // parallel prefix: highest set bit at or below each position
    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            flag[0][j] = word[j];
            lpos[0][j] = BIT_AW'(j);
        end
        for (int l = 1; l <= BIT_AW; l++)
        begin
            for (int j = 0; j < WORD_W; j++)
            begin
                if (j >= (1 << (l - 1)) && !flag[l-1][j])
                begin
                    flag[l][j] = flag[l-1][j - (1 << (l - 1))];
                    lpos[l][j] = lpos[l-1][j - (1 << (l - 1))];
                end
                else
                begin
                    flag[l][j] = flag[l-1][j];
                    lpos[l][j] = lpos[l-1][j];
                end
            end
        end
    end

    // clear run ending at each bit, compared against the wanted length
    always_comb
    begin
        run_j = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (flag[BIT_AW][j])
            begin
                run_j = CMP_W'(j) - CMP_W'(lpos[BIT_AW][j]);
            end
            else
            begin
                run_j = CMP_W'(carry) + CMP_W'(j) + CMP_W'(1);
            end
            ge[j] = (run_j >= CMP_W'(len)) && ((BIT_AW + 1)'(j) < nbits);
        end
    end

    // lowest qualifying bit
    always_comb
    begin
        low = ge & (~ge + WORD_W'(1));
        pos = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (low[j])
            begin
                pos = pos | BIT_AW'(j);
            end
        end
    end

    always_comb
    begin
        res.hit = |ge;
        res.pos = pos;
        if (flag[BIT_AW][WORD_W-1])
        begin
            res.run_out = RUN_W'(WORD_W - 1) - RUN_W'(lpos[BIT_AW][WORD_W-1]);
        end
        else
        begin
            res.run_out = carry + RUN_W'(WORD_W);
        end
    end

endmodule

// File: sv/bitmap_run_allocator.sv
// Allocation bitmap of 4096 bits kept in a 128 x 32 synchronous RAM with a registered
// read port, plus one valid bit per word so that clear-all only resets the valid bits.
// One request is worked on at a time: test and write read the word, then use it or
// write it back, and find scans the used words, reading one stored word per cycle
// through the RAM read port, and stops at the first word holding the run.
// Results sit in an output register, so a request can be taken while a result
// waits. The bytes_in_use register should only be written while no request is open.
module bitmap_run_allocator (
    input  logic      clk,
    input  logic      rst_n,
    bra_req_if.sink   req,
    bra_rsp_if.source rsp,
    bra_cfg_if.sink   cfg
);
    import bra_pkg::*;

    state_t              state_reg;
    state_t              state_next;

    logic [BYTES_W-1:0]  bytes_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                val_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [WORD_AW-1:0]  scan_word_reg;
    logic [RUN_W-1:0]    carry_reg;

    logic                res_bit_reg;
    logic                res_found_reg;
    logic [START_W-1:0]  res_start_reg;

    logic                out_valid_reg;
    logic                out_bit_reg;
    logic                out_found_reg;
    logic [START_W-1:0]  out_start_reg;

    logic                accept;
    logic                in_range;
    logic                find_trivial;
    logic                out_free;
    logic [USED_W-1:0]   prod;
    logic [USED_W-1:0]   limit;
    logic [WORD_AW-1:0]  last_word;
    logic [BIT_AW:0]     last_nbits;
    logic [BIT_AW:0]     nbits;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   bit_mask;
    logic [CMP_W-1:0]    start_full;
    store_req_t          store_req;
    eval_res_t           eval;

    bra_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_word (rd_word)
    );

    bra_word_eval u_eval (
        .word  (rd_word),
        .carry (carry_reg),
        .len   (len_reg),
        .nbits (nbits),
        .res   (eval)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = (32'(req.bit_index) < BITS);

    // used length in bits, saturated at the map size
    always_comb
    begin
        prod = {bytes_reg, 3'b000};
        if (32'(prod) > BITS)
        begin
            limit = USED_W'(BITS);
        end
        else
        begin
            limit = prod;
        end
        last_word  = WORD_AW'((limit - USED_W'(1)) >> BIT_AW);
        last_nbits = (limit[BIT_AW-1:0] == '0) ? (BIT_AW + 1)'(WORD_W)
                                               : {1'b0, limit[BIT_AW-1:0]};
        nbits      = (scan_word_reg == last_word) ? last_nbits : (BIT_AW + 1)'(WORD_W);
        find_trivial = (req.run_length == '0) || (32'(req.run_length) > 32'(limit));
        bit_mask   = WORD_W'(1) << idx_reg[BIT_AW-1:0];
        start_full = CMP_W'({scan_word_reg, eval.pos}) + CMP_W'(1) - CMP_W'(len_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_CLEAR: state_next = S_OUT;
                        FUNC_TEST:  state_next = in_range ? S_TEST : S_OUT;
                        FUNC_WRITE: state_next = in_range ? S_WRITE : S_OUT;
                        FUNC_FIND:  state_next = find_trivial ? S_OUT : S_SCAN;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_TEST:  state_next = S_OUT;
            S_WRITE: state_next = S_OUT;
            S_SCAN:
            begin
                if (eval.hit || scan_word_reg == last_word)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory requests
    always_comb
    begin
        store_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        FUNC_CLEAR: store_req.clr = 1'b1;
                        FUNC_TEST,
                        FUNC_WRITE:
                        begin
                            store_req.rd_en   = in_range;
                            store_req.rd_addr = WORD_AW'(req.bit_index >> BIT_AW);
                        end
                        FUNC_FIND:
                        begin
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = '0;
                        end
                        default: store_req.clr = 1'b0;
                    endcase
                end
            end
            S_WRITE:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = WORD_AW'(idx_reg >> BIT_AW);
                store_req.wr_data = val_reg ? (rd_word | bit_mask) : (rd_word & ~bit_mask);
            end
            S_SCAN:
            begin
                // prefetch the following word while this one is evaluated
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = scan_word_reg + WORD_AW'(1);
            end
            S_TEST,
            S_OUT:   store_req = '0;
            default: store_req = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bytes_reg     <= BYTES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                bytes_reg <= cfg.data;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg       <= req.bit_index;
            val_reg       <= req.set_value;
            len_reg       <= req.run_length;
            scan_word_reg <= '0;
            carry_reg     <= '0;
            res_bit_reg   <= 1'b0;
            res_found_reg <= 1'b0;
            res_start_reg <= '0;
        end
        if (state_reg == S_TEST)
        begin
            res_bit_reg <= rd_word[idx_reg[BIT_AW-1:0]];
        end
        if (state_reg == S_SCAN)
        begin
            scan_word_reg <= scan_word_reg + WORD_AW'(1);
            carry_reg     <= eval.run_out;
            if (eval.hit)
            begin
                res_found_reg <= 1'b1;
                res_start_reg <= start_full[START_W-1:0];
            end
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_bit_reg   <= res_bit_reg;
            out_found_reg <= res_found_reg;
            out_start_reg <= res_start_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bit_value   = out_bit_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.start_index = out_start_reg;

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_word_reg <= last_word)
        else $error("scan went past the last used word");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request transfer did not start work");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && eval.hit |-> 32'({scan_word_reg, eval.pos}) < 32'(limit))
        else $error("run found beyond the used length");

    a_write_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> !store_req.clr && !store_req.rd_en)
        else $error("write overlaps clear or read");

endmodule
